[hw/rtl/vpa_pkg.sv]
// Shared widths, types and constants of the vibrance pixel adjuster.
package vpa_pkg;

   // Sample format and channel lanes.
   localparam int SAMPLE_BITS = 16;
   localparam int PORT_W      = 16;
   localparam int NUM_CH      = 3;
   localparam int CH_RED      = 0;
   localparam int CH_GREEN    = 1;
   localparam int CH_BLUE     = 2;
   localparam logic [SAMPLE_BITS-1:0] MAX_SAMPLE = {SAMPLE_BITS{1'b1}};

   // Control register widths.
   localparam int INT_W     = 15;
   localparam int BAL_W     = 17;
   localparam int WGT_W     = 17;
   localparam int CSR_W     = 17;
   localparam int CSR_IDX_W = 3;

   // Gain path: k = intensity * balance, its magnitude times the saturation span.
   localparam int K_W       = INT_W + BAL_W;
   localparam int KMAG_W    = K_W - 1;
   localparam int T_W       = SAMPLE_BITS + 1;
   localparam int XM_W      = KMAG_W + T_W;
   localparam int GAIN_FRAC = 12;
   localparam int Y_W       = XM_W - GAIN_FRAC;
   localparam int Q_W       = 20;
   localparam int N_TERM    = (Y_W - 1) / SAMPLE_BITS;
   localparam int CORR_W    = 3;
   localparam int N_CORR    = (1 << CORR_W) - 1;
   localparam int R_W       = SAMPLE_BITS + CORR_W;
   localparam int GAIN_W    = Q_W + 1;
   localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(1 << GAIN_FRAC);

   // Luma and output mix.
   localparam int LP_W      = SAMPLE_BITS + WGT_W;
   localparam int LQ_W      = LP_W + 2;
   localparam int LQ_SPLIT  = 18;
   localparam int LQH_W     = LQ_W - LQ_SPLIT;
   localparam int PL_W      = LQ_SPLIT + Q_W;
   localparam int PH_W      = LQH_W + Q_W;
   localparam int CG_W      = SAMPLE_BITS + 1 + GAIN_W;
   localparam int CG_SHIFT  = 16;
   localparam int ACC_W     = LQ_W + Q_W + 2;
   localparam int OUT_SHIFT = 28;
   localparam int HI_W      = ACC_W - OUT_SHIFT;

   // Pipeline shape: three units of three stages each.
   localparam int UNIT_STAGES = 3;
   localparam int NUM_STAGES  = 3 * UNIT_STAGES;

   // Control register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CFG_INTENSITY,
      CFG_GREEN_BALANCE,
      CFG_BLUE_BALANCE,
      CFG_RED_BALANCE,
      CFG_GREEN_WEIGHT,
      CFG_BLUE_WEIGHT,
      CFG_RED_WEIGHT,
      CFG_ALTERNATE
   } cfg_index_type;

   typedef struct packed {
      logic signed [INT_W-1:0]        intensity;
      logic [NUM_CH-1:0][BAL_W-1:0]   balance;
      logic [NUM_CH-1:0][WGT_W-1:0]   weight;
      logic                           alternate;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      intensity: '0,
      balance:   {BAL_W'(4096), BAL_W'(4096), BAL_W'(4096)},
      weight:    {WGT_W'(13937), WGT_W'(46869), WGT_W'(4731)},
      alternate: 1'b0
   };

   // Fields carried from the front stages into the back stages.
   typedef struct packed {
      logic [NUM_CH-1:0][SAMPLE_BITS-1:0] sample;
      logic [LQ_W-1:0]                    luma;
      logic [NUM_CH-1:0]                  kneg;
      logic [PORT_W-1:0]                  alpha;
   } carry_type;

   typedef struct packed {
      carry_type                      carry;
      logic [NUM_CH-1:0][KMAG_W-1:0]  kmag;
      logic [NUM_CH-1:0][T_W-1:0]     span;
   } stats_type;

   typedef struct packed {
      carry_type                      carry;
      logic [NUM_CH-1:0][Q_W-1:0]     qabs;
      logic [NUM_CH-1:0][GAIN_W-1:0]  gain;
   } gain_type;

endpackage

[hw/rtl/vpa_stats.sv]
// Front stages: saturation span, luma sum and per-channel strength factor.
module vpa_stats (
   input  logic                                 clock,
   input  logic [vpa_pkg::UNIT_STAGES-1:0]      stage_en,
   input  vpa_pkg::cfg_type                     cfg,
   input  logic [vpa_pkg::PORT_W-1:0]           red_in,
   input  logic [vpa_pkg::PORT_W-1:0]           green_in,
   input  logic [vpa_pkg::PORT_W-1:0]           blue_in,
   input  logic [vpa_pkg::PORT_W-1:0]           alpha_in,
   output vpa_pkg::stats_type                   stats
);
   import vpa_pkg::*;

   logic [NUM_CH-1:0][SAMPLE_BITS-1:0] s1_sample_ff, s1_sample_in;
   logic [SAMPLE_BITS-1:0]             s1_span_ff, s1_span_in;
   logic [PORT_W-1:0]                  s1_alpha_ff;
   logic [SAMPLE_BITS-1:0]             hi_val, lo_val;

   logic [NUM_CH-1:0][SAMPLE_BITS-1:0] s2_sample_ff;
   logic [SAMPLE_BITS-1:0]             s2_span_ff;
   logic [PORT_W-1:0]                  s2_alpha_ff;
   logic [LP_W-1:0]                    s2_lp_ff [NUM_CH];
   logic [LP_W-1:0]                    s2_lp_in [NUM_CH];
   logic signed [K_W-1:0]              s2_k_ff [NUM_CH];
   logic signed [K_W-1:0]              s2_k_in [NUM_CH];

   stats_type                          s3_ff, s3_in;
   logic signed [K_W-1:0]              k_abs [NUM_CH];
   logic [NUM_CH-1:0]                  k_pos;

   // Stage 1: keep the low sample bits and find the max-min span.
   always_comb begin
      s1_sample_in[CH_RED]   = red_in[SAMPLE_BITS-1:0];
      s1_sample_in[CH_GREEN] = green_in[SAMPLE_BITS-1:0];
      s1_sample_in[CH_BLUE]  = blue_in[SAMPLE_BITS-1:0];
      hi_val = s1_sample_in[CH_RED];
      lo_val = s1_sample_in[CH_RED];
      for (int ch = 1; ch < NUM_CH; ch++) begin
         if (s1_sample_in[ch] > hi_val) hi_val = s1_sample_in[ch];
         if (s1_sample_in[ch] < lo_val) lo_val = s1_sample_in[ch];
      end
      s1_span_in = hi_val - lo_val;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s1_sample_ff <= s1_sample_in;
         s1_span_ff   <= s1_span_in;
         s1_alpha_ff  <= alpha_in;
      end
   end

   // Stage 2: luma products and the strength factor of each channel.
   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         s2_lp_in[ch] = s1_sample_ff[ch] * cfg.weight[ch];
         s2_k_in[ch]  = cfg.intensity * $signed(cfg.balance[ch]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s2_sample_ff <= s1_sample_ff;
         s2_span_ff   <= s1_span_ff;
         s2_alpha_ff  <= s1_alpha_ff;
         for (int ch = 0; ch < NUM_CH; ch++) begin
            s2_lp_ff[ch] <= s2_lp_in[ch];
            s2_k_ff[ch]  <= s2_k_in[ch];
         end
      end
   end

   // Stage 3: luma sum, factor magnitude and the signed saturation term.
   // The term is M - d when the saturation sign is positive, M + d otherwise.
   always_comb begin
      s3_in.carry.sample = s2_sample_ff;
      s3_in.carry.alpha  = s2_alpha_ff;
      s3_in.carry.luma   = LQ_W'(s2_lp_ff[CH_RED]) + LQ_W'(s2_lp_ff[CH_GREEN])
                         + LQ_W'(s2_lp_ff[CH_BLUE]);
      for (int ch = 0; ch < NUM_CH; ch++) begin
         s3_in.carry.kneg[ch] = s2_k_ff[ch][K_W-1];
         k_pos[ch]            = !s2_k_ff[ch][K_W-1] && (s2_k_ff[ch] != '0);
         k_abs[ch]            = s2_k_ff[ch][K_W-1] ? -s2_k_ff[ch] : s2_k_ff[ch];
         s3_in.kmag[ch]       = k_abs[ch][KMAG_W-1:0];
         if (cfg.alternate == k_pos[ch]) begin
            s3_in.span[ch] = T_W'(MAX_SAMPLE) - T_W'(s2_span_ff);
         end else begin
            s3_in.span[ch] = T_W'(MAX_SAMPLE) + T_W'(s2_span_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         s3_ff <= s3_in;
      end
   end

   assign stats = s3_ff;

endmodule

[hw/rtl/vpa_gain.sv]
// Middle stages: per-channel gain, with the divide by (M * 4096) done by folding.
module vpa_gain (
   input  logic                                 clock,
   input  logic [vpa_pkg::UNIT_STAGES-1:0]      stage_en,
   input  vpa_pkg::stats_type                   stats,
   output vpa_pkg::gain_type                    gain_out
);
   import vpa_pkg::*;

   carry_type          s4_carry_ff;
   logic [XM_W-1:0]    s4_xm_ff [NUM_CH];

   carry_type          s5_carry_ff;
   logic [Q_W-1:0]     s5_q0_ff [NUM_CH];
   logic [Q_W-1:0]     s5_q0_in [NUM_CH];
   logic [R_W-1:0]     s5_ylo_ff [NUM_CH];
   logic [R_W-1:0]     s5_ylo_in [NUM_CH];
   logic [Y_W-1:0]     y_val [NUM_CH];
   logic [Y_W-1:0]     fold_sum [NUM_CH];

   gain_type           s6_ff, s6_in;
   logic [R_W-1:0]     rem_val [NUM_CH];
   logic [CORR_W-1:0]  corr [NUM_CH];

   // Stage 4: magnitude of k times the saturation term.
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s4_carry_ff <= stats.carry;
         for (int ch = 0; ch < NUM_CH; ch++) begin
            s4_xm_ff[ch] <= stats.kmag[ch] * stats.span[ch];
         end
      end
   end

   // Stage 5: drop the Q.12 fraction, then estimate y / (2^n - 1) as the sum
   // of y shifted by n, 2n, ... which never overshoots the true quotient.
   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         y_val[ch]    = s4_xm_ff[ch][XM_W-1:GAIN_FRAC];
         fold_sum[ch] = '0;
         for (int j = 1; j <= N_TERM; j++) begin
            fold_sum[ch] = fold_sum[ch] + (y_val[ch] >> (j * SAMPLE_BITS));
         end
         s5_q0_in[ch]  = fold_sum[ch][Q_W-1:0];
         s5_ylo_in[ch] = y_val[ch][R_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s5_carry_ff <= s4_carry_ff;
         for (int ch = 0; ch < NUM_CH; ch++) begin
            s5_q0_ff[ch]  <= s5_q0_in[ch];
            s5_ylo_ff[ch] <= s5_ylo_in[ch];
         end
      end
   end

   // Stage 6: the remainder is below a few multiples of M, so a row of
   // compares gives the correction. Gain is unity plus or minus the quotient.
   always_comb begin
      s6_in.carry = s5_carry_ff;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         rem_val[ch] = s5_ylo_ff[ch]
                     - {s5_q0_ff[ch][CORR_W-1:0], {SAMPLE_BITS{1'b0}}}
                     + s5_q0_ff[ch][R_W-1:0];
         corr[ch] = '0;
         for (int i = 1; i <= N_CORR; i++) begin
            if (rem_val[ch] >= R_W'(i * int'(MAX_SAMPLE))) begin
               corr[ch] = corr[ch] + CORR_W'(1);
            end
         end
         s6_in.qabs[ch] = s5_q0_ff[ch] + Q_W'(corr[ch]);
         if (s5_carry_ff.kneg[ch]) begin
            s6_in.gain[ch] = UNITY_GAIN - GAIN_W'(s6_in.qabs[ch]);
         end else begin
            s6_in.gain[ch] = UNITY_GAIN + GAIN_W'(s6_in.qabs[ch]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         s6_ff <= s6_in;
      end
   end

   assign gain_out = s6_ff;

endmodule

[hw/rtl/vpa_mix.sv]
// Back stages: blend each channel with luma by its gain, then clamp.
module vpa_mix (
   input  logic                                 clock,
   input  logic [vpa_pkg::UNIT_STAGES-1:0]      stage_en,
   input  vpa_pkg::gain_type                    gain_in,
   output logic [vpa_pkg::PORT_W-1:0]           red_out,
   output logic [vpa_pkg::PORT_W-1:0]           green_out,
   output logic [vpa_pkg::PORT_W-1:0]           blue_out,
   output logic [vpa_pkg::PORT_W-1:0]           alpha_out
);
   import vpa_pkg::*;

   logic [NUM_CH-1:0]          s7_kneg_ff;
   logic [PORT_W-1:0]          s7_alpha_ff;
   logic [PL_W-1:0]            s7_plo_ff [NUM_CH];
   logic [PH_W-1:0]            s7_phi_ff [NUM_CH];
   logic signed [CG_W-1:0]     s7_cg_ff [NUM_CH];
   logic signed [CG_W-1:0]     s7_cg_in [NUM_CH];

   logic [PORT_W-1:0]          s8_alpha_ff;
   logic signed [ACC_W-1:0]    s8_acc_ff [NUM_CH];
   logic signed [ACC_W-1:0]    s8_acc_in [NUM_CH];
   logic signed [ACC_W-1:0]    luma_term [NUM_CH];

   logic [SAMPLE_BITS-1:0]     s9_out_ff [NUM_CH];
   logic [SAMPLE_BITS-1:0]     s9_out_in [NUM_CH];
   logic [PORT_W-1:0]          s9_alpha_ff;
   logic [HI_W-1:0]            hi_part [NUM_CH];

   // Stage 7: luma times the gain offset, split in two halves, and sample times gain.
   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         s7_cg_in[ch] = $signed({1'b0, gain_in.carry.sample[ch]}) * $signed(gain_in.gain[ch]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s7_kneg_ff  <= gain_in.carry.kneg;
         s7_alpha_ff <= gain_in.carry.alpha;
         for (int ch = 0; ch < NUM_CH; ch++) begin
            s7_plo_ff[ch] <= gain_in.carry.luma[LQ_SPLIT-1:0] * gain_in.qabs[ch];
            s7_phi_ff[ch] <= gain_in.carry.luma[LQ_W-1:LQ_SPLIT] * gain_in.qabs[ch];
            s7_cg_ff[ch]  <= s7_cg_in[ch];
         end
      end
   end

   // Stage 8: acc = sample * gain * 2^16 - luma * (gain - 1.0), in Q.28.
   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         luma_term[ch] = (ACC_W'(s7_phi_ff[ch]) << LQ_SPLIT) + ACC_W'(s7_plo_ff[ch]);
         s8_acc_in[ch] = (ACC_W'(s7_cg_ff[ch]) <<< CG_SHIFT)
                       + (s7_kneg_ff[ch] ? luma_term[ch] : -luma_term[ch]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s8_alpha_ff <= s7_alpha_ff;
         for (int ch = 0; ch < NUM_CH; ch++) begin
            s8_acc_ff[ch] <= s8_acc_in[ch];
         end
      end
   end

   // Stage 9: drop the fraction and clamp to the sample range.
   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         hi_part[ch] = s8_acc_ff[ch][ACC_W-1:OUT_SHIFT];
         if (s8_acc_ff[ch][ACC_W-1]) begin
            s9_out_in[ch] = '0;
         end else if (hi_part[ch] > HI_W'(MAX_SAMPLE)) begin
            s9_out_in[ch] = MAX_SAMPLE;
         end else begin
            s9_out_in[ch] = hi_part[ch][SAMPLE_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         s9_alpha_ff <= s8_alpha_ff;
         for (int ch = 0; ch < NUM_CH; ch++) begin
            s9_out_ff[ch] <= s9_out_in[ch];
         end
      end
   end

   assign red_out   = PORT_W'(s9_out_ff[CH_RED]);
   assign green_out = PORT_W'(s9_out_ff[CH_GREEN]);
   assign blue_out  = PORT_W'(s9_out_ff[CH_BLUE]);
   assign alpha_out = s9_alpha_ff;

endmodule

[hw/rtl/vibrance_pixel_adjust.sv]
// Top level of the vibrance pixel adjuster: control registers, stage flow control.
//
//   Port group   Direction   Handshake           Word
//   req_*        in          req_valid/stall     red, green, blue, alpha samples
//   rsp_*        out         rsp_valid/stall     adjusted red, green, blue, alpha
//   csr_*        in          csr_write_enable    register index and write data
//
// Nine register stages; one word is taken every cycle while req_stall is low.
// Three of the stages register multiply results.
// Reset clears all stage valid bits and loads the default register values.
// Each stage advances when it is empty or the stage after it advances, so a
// stalled output lets the earlier stages fill up before req_stall rises.
module vibrance_pixel_adjust (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [vpa_pkg::PORT_W-1:0]           req_red_in,
   input  logic [vpa_pkg::PORT_W-1:0]           req_green_in,
   input  logic [vpa_pkg::PORT_W-1:0]           req_blue_in,
   input  logic [vpa_pkg::PORT_W-1:0]           req_alpha_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [vpa_pkg::PORT_W-1:0]           rsp_red_out,
   output logic [vpa_pkg::PORT_W-1:0]           rsp_green_out,
   output logic [vpa_pkg::PORT_W-1:0]           rsp_blue_out,
   output logic [vpa_pkg::PORT_W-1:0]           rsp_alpha_out,
   input  logic                                 csr_write_enable,
   input  logic [vpa_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [vpa_pkg::CSR_W-1:0]            csr_data
);
   import vpa_pkg::*;

   cfg_type                 cfg_ff;
   logic [NUM_STAGES-1:0]   valid_ff, valid_in;
   logic [NUM_STAGES-1:0]   take;
   stats_type               stats;
   gain_type                gain;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_write_enable) begin
         unique case (cfg_index_type'(csr_index))
            CFG_INTENSITY:     cfg_ff.intensity         <= csr_data[INT_W-1:0];
            CFG_GREEN_BALANCE: cfg_ff.balance[CH_GREEN] <= csr_data[BAL_W-1:0];
            CFG_BLUE_BALANCE:  cfg_ff.balance[CH_BLUE]  <= csr_data[BAL_W-1:0];
            CFG_RED_BALANCE:   cfg_ff.balance[CH_RED]   <= csr_data[BAL_W-1:0];
            CFG_GREEN_WEIGHT:  cfg_ff.weight[CH_GREEN]  <= csr_data[WGT_W-1:0];
            CFG_BLUE_WEIGHT:   cfg_ff.weight[CH_BLUE]   <= csr_data[WGT_W-1:0];
            CFG_RED_WEIGHT:    cfg_ff.weight[CH_RED]    <= csr_data[WGT_W-1:0];
            CFG_ALTERNATE:     cfg_ff.alternate         <= csr_data[0];
         endcase
      end
   end

   // A stage may load when it is empty or its word moves on.
   always_comb begin
      take[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         take[i] = !valid_ff[i] || take[i+1];
      end
      valid_in = {valid_ff[NUM_STAGES-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            if (take[i]) valid_ff[i] <= valid_in[i];
         end
      end
   end

   assign req_stall = !take[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   vpa_stats u_stats (
      .clock     (clock),
      .stage_en  (take[UNIT_STAGES-1:0]),
      .cfg       (cfg_ff),
      .red_in    (req_red_in),
      .green_in  (req_green_in),
      .blue_in   (req_blue_in),
      .alpha_in  (req_alpha_in),
      .stats     (stats)
   );

   vpa_gain u_gain (
      .clock     (clock),
      .stage_en  (take[2*UNIT_STAGES-1:UNIT_STAGES]),
      .stats     (stats),
      .gain_out  (gain)
   );

   vpa_mix u_mix (
      .clock     (clock),
      .stage_en  (take[3*UNIT_STAGES-1:2*UNIT_STAGES]),
      .gain_in   (gain),
      .red_out   (rsp_red_out),
      .green_out (rsp_green_out),
      .blue_out  (rsp_blue_out),
      .alpha_out (rsp_alpha_out)
   );

`ifndef SYNTHESIS
   // The input side is held off only when every stage holds a word.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff))
      else $error("input stalled while the pipeline has an empty stage");

   // A word in the last inner stage reaches the output once the output moves.
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff[NUM_STAGES-2] && take[NUM_STAGES-1]) |=> rsp_valid)
      else $error("word lost between the last two stages");

   // Results never leave the sample range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_red_out <= PORT_W'(MAX_SAMPLE)) &&
                     (rsp_green_out <= PORT_W'(MAX_SAMPLE)) &&
                     (rsp_blue_out <= PORT_W'(MAX_SAMPLE))))
      else $error("output sample above the sample range");
`endif

endmodule

[tb/sv/tb_vibrance_pixel_adjust.sv]
// Self-checking testbench for the vibrance pixel adjuster: directed rows, then random phases.
module tb_vibrance_pixel_adjust;
   timeunit 1ns;
   timeprecision 1ps;

   import vpa_pkg::*;

   localparam int     HALF_PERIOD     = 6;
   localparam int     RESET_CYCLES    = 11;
   localparam int     NUM_PHASES      = 8;
   localparam int     WORDS_PER_PHASE = 192;
   localparam int     HOLD_CYCLES     = 64;
   localparam int     HOLD_AFTER      = 300;
   localparam longint FULL_SCALE      = (longint'(1) << SAMPLE_BITS) - 1;

   typedef struct packed {
      logic [PORT_W-1:0] red;
      logic [PORT_W-1:0] green;
      logic [PORT_W-1:0] blue;
      logic [PORT_W-1:0] alpha;
   } pixel_type;

   typedef enum logic {ROW_PIXEL, ROW_SETTING} row_kind_type;

   // One row of the directed plan: either a register write or a pixel word.
   typedef struct packed {
      row_kind_type     kind;
      cfg_index_type    index;
      logic [CSR_W-1:0] data;
      pixel_type        px;
      logic             known;
      pixel_type        want;
   } plan_row_type;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_stall;
   logic [PORT_W-1:0]    req_red_in       = '0;
   logic [PORT_W-1:0]    req_green_in     = '0;
   logic [PORT_W-1:0]    req_blue_in      = '0;
   logic [PORT_W-1:0]    req_alpha_in     = '0;
   logic                 rsp_valid;
   logic                 rsp_stall        = 1'b0;
   logic [PORT_W-1:0]    rsp_red_out;
   logic [PORT_W-1:0]    rsp_green_out;
   logic [PORT_W-1:0]    rsp_blue_out;
   logic [PORT_W-1:0]    rsp_alpha_out;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index        = '0;
   logic [CSR_W-1:0]     csr_data         = '0;

   // A typed-in expectation rides along with the word that is offered.
   logic                 given_valid      = 1'b0;
   pixel_type            given_px         = '0;

   // Local copy of the control registers, as the block should hold them.
   longint cur_intensity;
   longint cur_balance [NUM_CH];
   longint cur_weight  [NUM_CH];
   bit     cur_alternate;

   pixel_type    awaited_pixels[$];
   plan_row_type plan_q[$];

   int accepted_words   = 0;
   int checked_words    = 0;
   int settings_written = 0;
   int backed_up_cycles = 0;
   int fail_count       = 0;
   int directed_words   = 0;

   vibrance_pixel_adjust u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .req_alpha_in     (req_alpha_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_alpha_out    (rsp_alpha_out),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Register values after reset.
   task automatic load_reset_settings();
      cur_intensity          = 0;
      cur_balance[CH_RED]    = 4096;
      cur_balance[CH_GREEN]  = 4096;
      cur_balance[CH_BLUE]   = 4096;
      cur_weight[CH_RED]     = 4731;
      cur_weight[CH_GREEN]   = 46869;
      cur_weight[CH_BLUE]    = 13937;
      cur_alternate          = 1'b0;
   endtask

   // Signed registers keep their low bits as two's complement, the rest as unsigned.
   task automatic store_setting(input cfg_index_type idx, input logic [CSR_W-1:0] data);
      case (idx)
         CFG_INTENSITY:     cur_intensity         = longint'($signed(data[INT_W-1:0]));
         CFG_GREEN_BALANCE: cur_balance[CH_GREEN] = longint'($signed(data[BAL_W-1:0]));
         CFG_BLUE_BALANCE:  cur_balance[CH_BLUE]  = longint'($signed(data[BAL_W-1:0]));
         CFG_RED_BALANCE:   cur_balance[CH_RED]   = longint'($signed(data[BAL_W-1:0]));
         CFG_GREEN_WEIGHT:  cur_weight[CH_GREEN]  = longint'(data[WGT_W-1:0]);
         CFG_BLUE_WEIGHT:   cur_weight[CH_BLUE]   = longint'(data[WGT_W-1:0]);
         CFG_RED_WEIGHT:    cur_weight[CH_RED]    = longint'(data[WGT_W-1:0]);
         CFG_ALTERNATE:     cur_alternate         = data[0];
         default: ;
      endcase
   endtask

   // Gain for one channel from its balance and the pixel's span, then the luma mix.
   function automatic logic [PORT_W-1:0] mixed_channel(input longint c, input longint luma,
                                                       input longint bal, input longint span);
      longint k;
      longint sgn;
      longint gain;
      longint acc;
      longint q;
      k    = cur_intensity * bal;
      sgn  = (cur_alternate ? 1 : -1) * ((k > 0) ? 1 : -1);
      gain = (longint'(1) << GAIN_FRAC)
           + (k * (FULL_SCALE - sgn * span)) / (FULL_SCALE * (longint'(1) << GAIN_FRAC));
      acc  = luma * (longint'(1) << GAIN_FRAC) + (c * (longint'(1) << CG_SHIFT) - luma) * gain;
      if (acc <= 0) begin
         return '0;
      end
      q = acc >>> OUT_SHIFT;
      if (q > FULL_SCALE) begin
         q = FULL_SCALE;
      end
      return q[PORT_W-1:0];
   endfunction

   // Expected output word for one input word under the current registers.
   function automatic pixel_type adjusted_pixel(input pixel_type px);
      pixel_type out;
      longint r;
      longint g;
      longint b;
      longint hi;
      longint lo;
      longint luma;
      r    = longint'(px.red[SAMPLE_BITS-1:0]);
      g    = longint'(px.green[SAMPLE_BITS-1:0]);
      b    = longint'(px.blue[SAMPLE_BITS-1:0]);
      hi   = r;
      lo   = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      luma = g * cur_weight[CH_GREEN] + r * cur_weight[CH_RED] + b * cur_weight[CH_BLUE];
      out.red   = mixed_channel(r, luma, cur_balance[CH_RED], hi - lo);
      out.green = mixed_channel(g, luma, cur_balance[CH_GREEN], hi - lo);
      out.blue  = mixed_channel(b, luma, cur_balance[CH_BLUE], hi - lo);
      out.alpha = px.alpha;
      return out;
   endfunction

   task automatic check_field(input string name, input logic [PORT_W-1:0] want,
                              input logic [PORT_W-1:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Sample both channels and the register port at the rising edge.
   always @(posedge clock) begin : scoreboard
      pixel_type want;
      pixel_type got;
      if (reset) begin
         load_reset_settings();
      end else begin
         if (csr_write_enable) begin
            store_setting(cfg_index_type'(csr_index), csr_data);
            settings_written++;
         end
         if (req_valid && req_stall) begin
            backed_up_cycles++;
         end
         if (req_valid && !req_stall) begin
            if (given_valid) begin
               want       = given_px;
               want.alpha = req_alpha_in;
            end else begin
               want = adjusted_pixel('{req_red_in, req_green_in, req_blue_in, req_alpha_in});
            end
            awaited_pixels.push_back(want);
            accepted_words++;
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out};
            if (awaited_pixels.size() == 0) begin
               $display("%0t ns: output word %h with nothing expected", $time, got);
               fail_count++;
            end else begin
               want = awaited_pixels.pop_front();
               check_field("red", want.red, got.red);
               check_field("green", want.green, got.green);
               check_field("blue", want.blue, got.blue);
               check_field("alpha", want.alpha, got.alpha);
               checked_words++;
            end
         end
      end
   end

   task automatic put_setting(input cfg_index_type idx, input int value);
      plan_row_type row;
      row       = '0;
      row.kind  = ROW_SETTING;
      row.index = idx;
      row.data  = CSR_W'(value);
      plan_q.push_back(row);
   endtask

   task automatic put_pixel(input logic [PORT_W-1:0] r, input logic [PORT_W-1:0] g,
                            input logic [PORT_W-1:0] b, input logic [PORT_W-1:0] a);
      plan_row_type row;
      row      = '0;
      row.kind = ROW_PIXEL;
      row.px   = '{r, g, b, a};
      plan_q.push_back(row);
   endtask

   task automatic put_known(input logic [PORT_W-1:0] r, input logic [PORT_W-1:0] g,
                            input logic [PORT_W-1:0] b, input logic [PORT_W-1:0] a,
                            input logic [PORT_W-1:0] er, input logic [PORT_W-1:0] eg,
                            input logic [PORT_W-1:0] eb);
      plan_row_type row;
      row       = '0;
      row.kind  = ROW_PIXEL;
      row.px    = '{r, g, b, a};
      row.known = 1'b1;
      row.want  = '{er, eg, eb, a};
      plan_q.push_back(row);
   endtask

   // Offer one word at the falling edge and hold it until it is taken.
   task automatic send_pixel(input pixel_type px, input logic known, input pixel_type want);
      req_valid    <= 1'b1;
      req_red_in   <= px.red;
      req_green_in <= px.green;
      req_blue_in  <= px.blue;
      req_alpha_in <= px.alpha;
      given_valid  <= known;
      given_px     <= want;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic write_setting(input cfg_index_type idx, input logic [CSR_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= data;
      @(negedge clock);
   endtask

   // Stop offering, let every expected word come out, then let the pipeline settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (awaited_pixels.size() != 0) @(negedge clock);
      repeat (NUM_STAGES + 4) @(negedge clock);
   endtask

   // Register value: stated low end, high end, raw bits, zero, or in range.
   function automatic logic [CSR_W-1:0] pick_setting(input cfg_index_type idx, input int bias);
      int lo;
      int hi;
      int pick;
      case (idx)
         CFG_INTENSITY: begin
            lo = -8192;
            hi = 8192;
         end
         CFG_GREEN_BALANCE, CFG_BLUE_BALANCE, CFG_RED_BALANCE: begin
            lo = -40960;
            hi = 40960;
         end
         CFG_ALTERNATE: begin
            lo = 0;
            hi = 1;
         end
         default: begin
            lo = 0;
            hi = 65536;
         end
      endcase
      pick = (bias == 1) ? 0 : (bias == 2) ? 1 : $urandom_range(0, 9);
      case (pick)
         0:       return CSR_W'(lo);
         1:       return CSR_W'(hi);
         2:       return CSR_W'($urandom);
         3:       return '0;
         default: return CSR_W'(lo + int'($urandom_range(0, hi - lo)));
      endcase
   endfunction

   // Random word: mostly free, some near gray, some at the rails, some dark.
   function automatic pixel_type random_pixel();
      pixel_type         p;
      int                shape;
      logic [PORT_W-1:0] base;
      p.red   = PORT_W'($urandom);
      p.green = PORT_W'($urandom);
      p.blue  = PORT_W'($urandom);
      p.alpha = PORT_W'($urandom);
      base    = PORT_W'($urandom);
      shape   = $urandom_range(0, 9);
      case (shape)
         6: begin
            p.red   = base;
            p.green = base + PORT_W'($urandom_range(0, 255));
            p.blue  = base - PORT_W'($urandom_range(0, 255));
         end
         7: begin
            p.red   = {PORT_W{$urandom_range(0, 1) == 1}};
            p.green = {PORT_W{$urandom_range(0, 1) == 1}};
            p.blue  = {PORT_W{$urandom_range(0, 1) == 1}};
         end
         8: begin
            p.green = {PORT_W{$urandom_range(0, 1) == 1}};
         end
         9: begin
            p.red   = PORT_W'($urandom_range(0, 255));
            p.green = PORT_W'($urandom_range(0, 255));
            p.blue  = PORT_W'($urandom_range(0, 255));
         end
         default: ;
      endcase
      return p;
   endfunction

   // Main stimulus: reset, directed plan, random phases, final drain.
   initial begin : stimulus
      int phase;
      int sent;
      int burst;
      int gap;
      bit writing;
      writing = 1'b0;

      // Reset registers leave every pixel unchanged.
      put_known(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      put_known(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      put_known(16'hFFFF, 16'h0000, 16'h8000, 16'h1234, 16'hFFFF, 16'h0000, 16'h8000);
      put_known(16'h0000, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001);
      put_known(16'h5A5A, 16'hA5A5, 16'h0F0F, 16'hF0F0, 16'h5A5A, 16'hA5A5, 16'h0F0F);
      // Strongest positive intensity; black stays black.
      put_setting(CFG_INTENSITY, 8192);
      put_known(16'h0000, 16'h0000, 16'h0000, 16'hBEEF, 16'h0000, 16'h0000, 16'h0000);
      put_pixel(16'h8000, 16'h8000, 16'h8000, 16'h0000);
      put_pixel(16'hFFFF, 16'h0000, 16'h0000, 16'h0001);
      put_pixel(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
      // Positive saturation sign.
      put_setting(CFG_ALTERNATE, 1);
      put_pixel(16'hFFFF, 16'h0000, 16'h0000, 16'h0002);
      put_pixel(16'h4000, 16'h8000, 16'hC000, 16'h0003);
      // Strongest negative intensity.
      put_setting(CFG_INTENSITY, -8192);
      put_pixel(16'hFFFF, 16'h0000, 16'h0000, 16'h0004);
      put_pixel(16'h8000, 16'h8000, 16'h8000, 16'h0005);
      // Balance extremes, and a zero balance that leaves blue unchanged.
      put_setting(CFG_RED_BALANCE, 40960);
      put_setting(CFG_GREEN_BALANCE, -40960);
      put_setting(CFG_BLUE_BALANCE, 0);
      put_pixel(16'h2000, 16'hC000, 16'h7000, 16'h0006);
      put_pixel(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0007);
      put_setting(CFG_ALTERNATE, 0);
      put_pixel(16'h2000, 16'hC000, 16'h7000, 16'h0008);
      // Luma from green alone.
      put_setting(CFG_GREEN_WEIGHT, 65536);
      put_setting(CFG_BLUE_WEIGHT, 0);
      put_setting(CFG_RED_WEIGHT, 0);
      put_pixel(16'h1111, 16'hEEEE, 16'h8888, 16'h0009);
      // Weights summing well above one; the red and green outputs clamp.
      put_setting(CFG_GREEN_WEIGHT, 131071);
      put_setting(CFG_BLUE_WEIGHT, 131071);
      put_setting(CFG_RED_WEIGHT, 131071);
      put_pixel(16'h8000, 16'h4000, 16'h2000, 16'h000A);
      // Registers beyond their stated range wrap to the register width.
      put_setting(CFG_INTENSITY, 16383);
      put_setting(CFG_RED_BALANCE, 65535);
      put_setting(CFG_GREEN_BALANCE, 131071);
      put_pixel(16'hFFFF, 16'h0000, 16'h8000, 16'h000B);
      put_known(16'h0000, 16'h0000, 16'h0000, 16'h000C, 16'h0000, 16'h0000, 16'h0000);
      // Zero intensity gives unity gain whatever the weights and sign mode.
      put_setting(CFG_INTENSITY, 0);
      put_setting(CFG_ALTERNATE, 1);
      put_known(16'h1234, 16'h8765, 16'h0000, 16'h000D, 16'h1234, 16'h8765, 16'h0000);
      put_known(16'hFFFF, 16'h0001, 16'hFFFE, 16'h000E, 16'hFFFF, 16'h0001, 16'hFFFE);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Walk the directed plan; writes wait until the pipeline is empty.
      for (int i = 0; i < plan_q.size(); i++) begin
         if (plan_q[i].kind == ROW_SETTING) begin
            if (!writing) begin
               wait_idle();
            end
            write_setting(plan_q[i].index, plan_q[i].data);
            writing = 1'b1;
         end else begin
            csr_write_enable <= 1'b0;
            writing = 1'b0;
            send_pixel(plan_q[i].px, plan_q[i].known, plan_q[i].want);
            directed_words++;
         end
      end

      // Random phases: new registers, then bursts of words with gaps, except in phase 3.
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         wait_idle();
         for (int r = 0; r < 8; r++) begin
            write_setting(cfg_index_type'(r),
                          pick_setting(cfg_index_type'(r), (phase < 2) ? phase + 1 : 0));
         end
         csr_write_enable <= 1'b0;
         sent = 0;
         while (sent < WORDS_PER_PHASE) begin
            burst = $urandom_range(1, 24);
            if (burst > WORDS_PER_PHASE - sent) begin
               burst = WORDS_PER_PHASE - sent;
            end
            for (int w = 0; w < burst; w++) begin
               send_pixel(random_pixel(), 1'b0, '0);
               sent++;
            end
            gap = (phase == 3) ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
      end

      wait_idle();
      fail_count += awaited_pixels.size();
      $display("Covered %0d pixel words (%0d directed) and %0d register writes over %0d phases.",
               checked_words, directed_words, settings_written, NUM_PHASES);
      $display("Input was held off for %0d cycles; %0d mismatches found.",
               backed_up_cycles, fail_count);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Output side: stall patterns that change every so often, plus one long hold-off.
   initial begin : sink
      int mode;
      int span;
      bit held;
      held = 1'b0;
      wait (!reset);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 120);
         for (int n = 0; n < span; n++) begin
            @(negedge clock);
            if (!held && accepted_words >= HOLD_AFTER) begin
               held = 1'b1;
               rsp_stall <= 1'b1;
               repeat (HOLD_CYCLES) @(negedge clock);
            end
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ((n % 4) == 3);
               default: rsp_stall <= ($urandom_range(0, 1) == 1);
            endcase
         end
      end
   end

   // Hard stop in case the block hangs.
   initial begin : watchdog
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

[vibrance_pixel_adjust.f]
hw/rtl/vpa_pkg.sv
hw/rtl/vpa_stats.sv
hw/rtl/vpa_gain.sv
hw/rtl/vpa_mix.sv
hw/rtl/vibrance_pixel_adjust.sv
tb/sv/tb_vibrance_pixel_adjust.sv
